FILE: sv/spi_rfm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// spi_rfm_pkg: shared types and constants of the SPI register field master
// Field widths of the item ports, command codes, sequence states and the
// structs passed between the top level and the core.
// ============================================================================
package spi_rfm_pkg;

	// Fixed port widths
	localparam int CMD_BITS    = 3;
	localparam int ADDR_BITS   = 15;
	localparam int VALUE_BITS  = 16;
	localparam int FIELD_BITS  = 8;
	localparam int NIBBLE_BITS = 4;
	localparam int RESULT_BITS = 16;

	// Command codes on the cmd port
	localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_WRITE  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_MODIFY = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_GET    = 3'd4;

	// Running sequence; codes 1..4 match the command codes
	typedef enum logic [CMD_BITS-1:0] {
		OP_IDLE      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_READ      = 3'd2,
		OP_MODIFY    = 3'd3,
		OP_GET       = 3'd4,
		OP_WRITEBACK = 3'd5
	} op_t;

	// One input item (one half serial-clock tick)
	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic [ADDR_BITS-1:0]  reg_address;
		logic [VALUE_BITS-1:0] write_value;
		logic [FIELD_BITS-1:0] field_spec;
		logic                  miso_bit;
	} item_t;

	// One result item
	typedef struct packed {
		logic                   sclk_level;
		logic                   sen_level;
		logic                   mosi_level;
		logic                   busy_res;
		logic                   done_res;
		logic [RESULT_BITS-1:0] read_result;
		logic                   cmd_ignored;
	} result_t;

endpackage

FILE: sv/spi_rfm_field.sv
`timescale 1ns / 1ps
// ============================================================================
// spi_rfm_field: register field extract and merge
// Builds the msb..lsb mask from the field spec, pulls the field down to bit 0
// and merges a new field value into the word read back.
// ============================================================================
module spi_rfm_field #(
	parameter int WORD_BITS = 16
) (
	input  logic [WORD_BITS-1:0]               in_word,
	input  logic [WORD_BITS-1:0]               field_value,
	input  logic [spi_rfm_pkg::FIELD_BITS-1:0] field_spec,
	output logic [WORD_BITS-1:0]               merged_word,
	output logic [spi_rfm_pkg::RESULT_BITS-1:0] field_out
);
	import spi_rfm_pkg::*;

	logic [NIBBLE_BITS-1:0] msb;
	logic [NIBBLE_BITS-1:0] lsb;
	logic [WORD_BITS-1:0]   fmask;
	logic [WORD_BITS-1:0]   extracted;

	assign msb = field_spec[FIELD_BITS-1:NIBBLE_BITS];
	assign lsb = field_spec[NIBBLE_BITS-1:0];

	// Mask is empty when msb is below lsb; bits past the word drop out
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			fmask[i] = (i >= int'(lsb)) && (i <= int'(msb));
		end
	end

	assign extracted   = (in_word & fmask) >> lsb;
	assign field_out   = RESULT_BITS'(extracted);
	assign merged_word = (in_word & ~fmask) | ((field_value << lsb) & fmask);

endmodule

FILE: sv/spi_rfm_core.sv
`timescale 1ns / 1ps
// ============================================================================
// spi_rfm_core: SPI sequencer state and one-tick step
// Holds the transaction state and pin levels; each enabled tick advances the
// sequence by one half serial-clock period and forms that tick's result.
// ============================================================================
module spi_rfm_core #(
	parameter int WORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  spi_rfm_pkg::item_t   item,
	output spi_rfm_pkg::result_t result
);
	import spi_rfm_pkg::*;

	localparam int AW = WORD_BITS - 1;
	localparam int FW = 2 * WORD_BITS;
	localparam int PW = $clog2(4 * WORD_BITS + 3);
	localparam int SW = $clog2(FW);

	localparam logic [PW-1:0]   PH_2W     = PW'(2 * WORD_BITS);
	localparam logic [PW-1:0]   PH_4W     = PW'(4 * WORD_BITS);
	localparam logic [PW-1:0]   PH_4W1    = PW'(4 * WORD_BITS + 1);
	localparam logic [PW-2:0]   LAST_POS  = (PW-1)'(FW - 1);

	// Sequence state
	op_t                  op_q,        op_d;
	logic [PW-1:0]        phase_q,     phase_d;
	logic [FW-1:0]        frame_q,     frame_d;
	logic [WORD_BITS-1:0] in_shift_q,  in_shift_d;
	logic [AW-1:0]        addr_q,      addr_d;
	logic [WORD_BITS-1:0] value_q,     value_d;
	logic [FIELD_BITS-1:0] field_q,    field_d;
	logic                 sclk_q,      sclk_d;
	logic                 sen_q,       sen_d;
	logic                 mosi_q,      mosi_d;

	logic                   is_cmd;
	logic                   advance;
	logic                   busy, done, ignored;
	logic [RESULT_BITS-1:0] res;
	logic [WORD_BITS-1:0]   merged_word;
	logic [RESULT_BITS-1:0] field_out;

	assign is_cmd = (item.cmd == CMD_WRITE) || (item.cmd == CMD_READ) ||
	                (item.cmd == CMD_MODIFY) || (item.cmd == CMD_GET);

	spi_rfm_field #(
		.WORD_BITS(WORD_BITS)
	) u_field (
		.in_word    (in_shift_q),
		.field_value(value_q),
		.field_spec (field_q),
		.merged_word(merged_word),
		.field_out  (field_out)
	);

	// Next state of one tick
	always_comb begin
		logic [PW-1:0]   k;
		logic [PW-2:0]   pos;
		op_d       = op_q;
		phase_d    = phase_q;
		frame_d    = frame_q;
		in_shift_d = in_shift_q;
		addr_d     = addr_q;
		value_d    = value_q;
		field_d    = field_q;
		sclk_d     = sclk_q;
		sen_d      = sen_q;
		mosi_d     = mosi_q;
		busy       = 1'b0;
		done       = 1'b0;
		ignored    = 1'b0;
		res        = '0;
		advance    = 1'b1;
		k          = phase_q - PW'(1);
		pos        = LAST_POS - k[PW-1:1];

		// Command start, or flag a command that comes while busy
		if (op_q == OP_IDLE) begin
			if (is_cmd) begin
				addr_d     = AW'(item.reg_address);
				value_d    = WORD_BITS'(item.write_value);
				field_d    = item.field_spec;
				op_d       = op_t'(item.cmd);
				phase_d    = '0;
				in_shift_d = '0;
				if (item.cmd == CMD_WRITE) begin
					frame_d = {1'b1, AW'(item.reg_address), WORD_BITS'(item.write_value)};
				end else begin
					frame_d = {1'b0, AW'(item.reg_address), {WORD_BITS{1'b0}}};
				end
			end
		end else if (is_cmd) begin
			ignored = 1'b1;
		end

		// Pin levels for this half period
		if (op_d != OP_IDLE) begin
			busy = 1'b1;
			if (phase_d == '0) begin
				sclk_d = 1'b0;
				sen_d  = 1'b0;
			end else if (op_d == OP_WRITE || op_d == OP_WRITEBACK) begin
				if (phase_d <= PH_4W) begin
					sclk_d = ~phase_d[0];
					if (phase_d[0]) begin
						mosi_d = frame_d[pos[SW-1:0]];
					end
				end else begin
					sclk_d  = 1'b0;
					sen_d   = 1'b1;
					mosi_d  = 1'b1;
					done    = 1'b1;
					res     = (op_d == OP_WRITEBACK) ? RESULT_BITS'(value_d) : '0;
					op_d    = OP_IDLE;
					advance = 1'b0;
				end
			end else if (phase_d <= PH_2W) begin
				// address frame
				sclk_d = ~phase_d[0];
				if (phase_d[0]) begin
					mosi_d = frame_d[pos[SW-1:0]];
				end
			end else if (phase_d <= PH_4W) begin
				// data frame, sample on the rising edge
				sclk_d = ~phase_d[0];
				if (phase_d[0]) begin
					mosi_d = 1'b1;
				end else begin
					in_shift_d = {in_shift_d[WORD_BITS-2:0], item.miso_bit};
				end
			end else if (phase_d == PH_4W1) begin
				sclk_d = 1'b0;
			end else begin
				sclk_d  = 1'b0;
				sen_d   = 1'b1;
				mosi_d  = 1'b1;
				advance = 1'b0;
				if (op_d == OP_READ) begin
					done = 1'b1;
					res  = RESULT_BITS'(in_shift_q);
					op_d = OP_IDLE;
				end else if (op_d == OP_GET) begin
					done = 1'b1;
					res  = field_out;
					op_d = OP_IDLE;
				end else begin
					// modify: write the merged word straight back
					value_d = merged_word;
					frame_d = {1'b1, addr_q, merged_word};
					op_d    = OP_WRITEBACK;
					phase_d = '0;
				end
			end
			if (advance) begin
				phase_d = phase_d + PW'(1);
			end else if (op_d == OP_IDLE) begin
				phase_d = '0;
			end
		end
	end

	// Result of this tick
	always_comb begin
		result.sclk_level  = sclk_d;
		result.sen_level   = sen_d;
		result.mosi_level  = mosi_d;
		result.busy_res    = busy;
		result.done_res    = done;
		result.read_result = res;
		result.cmd_ignored = ignored;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_IDLE;
			phase_q    <= '0;
			frame_q    <= '0;
			in_shift_q <= '0;
			addr_q     <= '0;
			value_q    <= '0;
			field_q    <= '0;
			sclk_q     <= 1'b0;
			sen_q      <= 1'b1;
			mosi_q     <= 1'b1;
		end else if (en) begin
			op_q       <= op_d;
			phase_q    <= phase_d;
			frame_q    <= frame_d;
			in_shift_q <= in_shift_d;
			addr_q     <= addr_d;
			value_q    <= value_d;
			field_q    <= field_d;
			sclk_q     <= sclk_d;
			sen_q      <= sen_d;
			mosi_q     <= mosi_d;
		end
	end

endmodule

FILE: sv/spi_register_field_master.sv
`timescale 1ns / 1ps
// ============================================================================
// spi_register_field_master: SPI master for register read/write/field access
// Top level with input and result registers around the sequencer core.
// ============================================================================
// Usage:
//   Each input item is one half serial-clock period. It carries a command
//   (tick only, write, read, modify field, get field), its operands and the
//   sampled slave data bit. Each item gives exactly one result item with the
//   pin levels for that half period plus busy, done, read data and an
//   ignored-command flag. Drive the pins from accepted results in order.
//   The item is held in the input register and its result is registered in
//   the result register; the core step between them is combinational.
//   Throughput is one item per cycle while the receiver does not stall.
//   A write runs 4*WORD_BITS+2 items, a read or get field 4*WORD_BITS+3,
//   a modify field both back to back. Commands that come while a sequence
//   runs are dropped and flagged.
//   Reset clears the valid flags of both registers and idles the core's pin state at sclk 0, sen 1, mosi 1.
//   When the receiver stalls, the result holds and the input register keeps
//   its item; in_stall rises once both are full.
// ============================================================================
module spi_register_field_master #(
	parameter int WORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [spi_rfm_pkg::CMD_BITS-1:0]     cmd,
	input  logic [spi_rfm_pkg::ADDR_BITS-1:0]    reg_address,
	input  logic [spi_rfm_pkg::VALUE_BITS-1:0]   write_value,
	input  logic [spi_rfm_pkg::FIELD_BITS-1:0]   field_spec,
	input  logic                                 miso_bit,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 sclk_level,
	output logic                                 sen_level,
	output logic                                 mosi_level,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [spi_rfm_pkg::RESULT_BITS-1:0]  read_result,
	output logic                                 cmd_ignored
);
	import spi_rfm_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t step_result;
	logic    step_en;
	logic    in_accept;

	// Step when there is an item and room in the result register
	assign step_en   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !step_en;
	assign in_accept = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !step_en);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= '{cmd: cmd, reg_address: reg_address, write_value: write_value,
			             field_spec: field_spec, miso_bit: miso_bit};
		end
	end

	spi_rfm_core #(
		.WORD_BITS(WORD_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (step_en),
		.item  (item_s1),
		.result(step_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= step_result;
		end
	end

	assign out_valid   = out_valid_q;
	assign sclk_level  = result_q.sclk_level;
	assign sen_level   = result_q.sen_level;
	assign mosi_level  = result_q.mosi_level;
	assign busy_res    = result_q.busy_res;
	assign done_res    = result_q.done_res;
	assign read_result = result_q.read_result;
	assign cmd_ignored = result_q.cmd_ignored;

endmodule

FILE: sv/spi_rfm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// spi_rfm_checker: port-level checks of the SPI register field master
// Watches the result channel for handshake holding and result consistency.
// ============================================================================
module spi_rfm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                sclk_level,
	input logic                                sen_level,
	input logic                                mosi_level,
	input logic                                busy_res,
	input logic                                done_res,
	input logic [spi_rfm_pkg::RESULT_BITS-1:0] read_result,
	input logic                                cmd_ignored
);

	// A stalled result stays valid; its read data, done, enable and ignored flag stay put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_result) &&
		$stable(done_res) && $stable(sen_level) && $stable(cmd_ignored))
		else $error("stalled result changed");

	// The finishing tick releases enable and data-out with the clock low
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> sen_level && mosi_level && !sclk_level)
		else $error("sequence end without idle pin levels");

	// Done only comes within a running sequence
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done outside a sequence");

	// Read data is zero except on the finishing tick
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> read_result == '0)
		else $error("read data set without done");

	// Idle ticks keep enable high
	a_idle_sen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> sen_level && !sclk_level)
		else $error("pins active while idle");

endmodule

bind spi_register_field_master spi_rfm_checker u_spi_rfm_checker (.*);
